// ----- src/brwt_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and command/status structs for the repeat window tracker
// no dependencies

package brwt_pkg;

   localparam int VALUE_BITS = 16;
   localparam int RING_DEPTH = 4096;
   localparam int RING_BITS  = $clog2(RING_DEPTH);
   localparam int FILL_BITS  = RING_BITS + 1;
   localparam int COUNT_DEPTH = 1 << VALUE_BITS;

   localparam int IN_VALUE_BITS = 16;
   localparam int LEN_BITS      = 13;
   localparam int CNT_BITS      = 13;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam logic CSR_IDX_MAX_REPEATS = 1'b0;
   localparam logic [LEN_BITS-1:0] MAX_REPEATS_RESET = LEN_BITS'(1);

   // controller to datapath
   typedef struct packed {
      logic clear;       // write zero to the count entry at the sweep address
      logic accept;      // take a new word, start the count read
      logic capture_cnt; // latch the count of the new value
      logic evict_rd;    // latch oldest value, start its count read
      logic evict_wr;    // write back decremented count, advance head
      logic append;      // write ring tail and count, load result
      logic drain_set;   // start emptying the window
      logic drain_done;  // window empty, return head and best to zero
   } brwt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic evict_needed;
      logic drain;
      logic last;
      logic rsp_busy;
   } brwt_status_type;

endpackage

// ----- src/brwt_ram.sv -----
`timescale 1ns / 1ps
// generic simple dual port ram, one write and one registered read port
// no dependencies

module brwt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- src/brwt_ctrl.sv -----
`timescale 1ns / 1ps
// controller state machine for the repeat window tracker
// depends on brwt_pkg

module brwt_ctrl import brwt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  brwt_status_type status,
   output brwt_cmd_type    cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_CNT    = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_EVICT  = 3'd4;
   localparam logic [2:0] S_APPEND = 3'd5;
   localparam logic [2:0] S_SYNC   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = S_CNT;
            end
         end
         S_CNT: begin
            cmd.capture_cnt = 1'b1;
            state_in        = S_CHECK;
         end
         S_CHECK: begin
            if (status.evict_needed) begin
               cmd.evict_rd = 1'b1;
               state_in     = S_EVICT;
            end else if (status.drain) begin
               cmd.drain_done = 1'b1;
               state_in       = S_IDLE;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_EVICT: begin
            cmd.evict_wr = 1'b1;
            state_in     = S_CHECK;
         end
         S_APPEND: begin
            if (!status.rsp_busy) begin
               cmd.append = 1'b1;
               if (status.last) begin
                  cmd.drain_set = 1'b1;
                  state_in      = S_SYNC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SYNC: begin
            // ring read of the head entry settles after the tail write
            state_in = S_CHECK;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/brwt_dp.sv -----
`timescale 1ns / 1ps
// datapath: count table, window ring, head/fill/best registers, result register
// depends on brwt_pkg and brwt_ram

module brwt_dp import brwt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  brwt_cmd_type             cmd,
   output brwt_status_type          status,
   input  logic [IN_VALUE_BITS-1:0] req_value,
   input  logic                     req_last_item,
   input  logic [LEN_BITS-1:0]      limit,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [LEN_BITS-1:0]      rsp_window_length,
   output logic [LEN_BITS-1:0]      rsp_best_length,
   output logic                     rsp_sequence_done
);

   logic [VALUE_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  last_ff, last_in;
   logic [CNT_BITS-1:0]   cnt_v_ff, cnt_v_in;
   logic [VALUE_BITS-1:0] old_ff, old_in;
   logic [RING_BITS-1:0]  head_ff, head_in;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic [FILL_BITS-1:0]  best_ff, best_in;
   logic                  drain_ff, drain_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEN_BITS-1:0]   rsp_len_ff, rsp_len_in;
   logic [LEN_BITS-1:0]   rsp_best_ff, rsp_best_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic [VALUE_BITS-1:0] cnt_raddr, cnt_waddr;
   logic [CNT_BITS-1:0]   cnt_rdata, cnt_wdata;
   logic                  cnt_wen;
   logic [VALUE_BITS-1:0] ring_rdata;
   logic [RING_BITS-1:0]  tail;
   logic [FILL_BITS-1:0]  fill_plus;
   logic                  at_limit;

   assign tail      = head_ff + fill_ff[RING_BITS-1:0];
   assign fill_plus = fill_ff + FILL_BITS'(1);
   assign at_limit  = cnt_v_ff >= limit;

   assign status.clear_last   = (clr_addr_ff == {VALUE_BITS{1'b1}});
   assign status.evict_needed = (fill_ff != '0) &&
                                (drain_ff || at_limit || fill_ff == FILL_BITS'(RING_DEPTH));
   assign status.drain        = drain_ff;
   assign status.last         = last_ff;
   assign status.rsp_busy     = rsp_valid_ff && !rsp_ready;

   // count table ports
   always_comb begin
      if (cmd.accept) begin
         cnt_raddr = VALUE_BITS'(req_value);
      end else if (cmd.evict_rd) begin
         cnt_raddr = ring_rdata;
      end else begin
         cnt_raddr = value_ff;
      end
      cnt_wen   = cmd.clear || cmd.evict_wr || cmd.append;
      cnt_waddr = clr_addr_ff;
      cnt_wdata = '0;
      if (cmd.evict_wr) begin
         cnt_waddr = old_ff;
         cnt_wdata = (cnt_rdata != '0) ? cnt_rdata - CNT_BITS'(1) : '0;
      end else if (cmd.append) begin
         cnt_waddr = value_ff;
         cnt_wdata = cnt_v_ff + CNT_BITS'(1);
      end
   end

   always_comb begin
      clr_addr_in  = cmd.clear ? clr_addr_ff + VALUE_BITS'(1) : clr_addr_ff;
      value_in     = cmd.accept ? VALUE_BITS'(req_value) : value_ff;
      last_in      = cmd.accept ? req_last_item : last_ff;
      cnt_v_in     = cnt_v_ff;
      old_in       = cmd.evict_rd ? ring_rdata : old_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      best_in      = best_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_len_in   = rsp_len_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_done_in  = rsp_done_ff;
      if (cmd.capture_cnt) begin
         cnt_v_in = cnt_rdata;
      end
      if (cmd.evict_wr) begin
         head_in = head_ff + RING_BITS'(1);
         fill_in = fill_ff - FILL_BITS'(1);
         if (old_ff == value_ff && cnt_v_ff != '0) begin
            cnt_v_in = cnt_v_ff - CNT_BITS'(1);
         end
      end
      if (cmd.append) begin
         fill_in      = fill_plus;
         best_in      = (fill_plus > best_ff) ? fill_plus : best_ff;
         rsp_valid_in = 1'b1;
         rsp_len_in   = LEN_BITS'(fill_plus);
         rsp_best_in  = LEN_BITS'((fill_plus > best_ff) ? fill_plus : best_ff);
         rsp_done_in  = last_ff;
      end
      if (cmd.drain_set) begin
         drain_in = 1'b1;
      end
      if (cmd.drain_done) begin
         head_in  = '0;
         best_in  = '0;
         drain_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         best_ff      <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         best_ff      <= best_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      last_ff     <= last_in;
      cnt_v_ff    <= cnt_v_in;
      old_ff      <= old_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_best_ff <= rsp_best_in;
      rsp_done_ff <= rsp_done_in;
   end

   brwt_ram #(
      .WIDTH (CNT_BITS),
      .DEPTH (COUNT_DEPTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wen),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   // read address follows the next head so the oldest entry is ready in the next cycle
   brwt_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (RING_DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (tail),
      .wr_data (value_ff),
      .rd_addr (head_in),
      .rd_data (ring_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_window_length = rsp_len_ff;
   assign rsp_best_length   = rsp_best_ff;
   assign rsp_sequence_done = rsp_done_ff;

endmodule

// ----- src/bounded_repeat_window_tracker.sv -----
`timescale 1ns / 1ps
// top level of the repeat window tracker: csr block, controller and datapath
// depends on brwt_pkg, brwt_ctrl, brwt_dp
//
// usage
//  - req channel takes one word per sequence element (value, last_item);
//    rsp channel returns one word per element (window_length, best_length,
//    sequence_done), both valid/ready
//  - the window holds the latest elements with at most max_repeats copies of
//    any value; older elements are evicted before a new value is appended
//  - an element passes through accept, count read, limit check and append,
//    and its result is registered at the append step; each evicted element
//    adds a count read and write-back; each element is evicted once, and
//    the throughput is set by the single read/write port pair of the
//    count table
//  - a word marked last is followed by a drain that evicts every element in
//    the window, during which no new word is accepted
//  - after reset the count table is swept to zero, one entry a cycle, over
//    all 2^VALUE_BITS entries; req_ready stays low during the sweep while csr
//    writes are taken as usual
//  - a stalled rsp keeps its word; the next word may be accepted and worked
//    up to the append step while the previous result waits
//  - max_repeats sits at byte address 0, reset value 1; zero acts as one

module bounded_repeat_window_tracker import brwt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // element channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [IN_VALUE_BITS-1:0] req_value,
   input  logic                     req_last_item,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [LEN_BITS-1:0]      rsp_window_length,
   output logic [LEN_BITS-1:0]      rsp_best_length,
   output logic                     rsp_sequence_done,
   // csr port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   brwt_cmd_type    cmd;
   brwt_status_type status;

   logic [LEN_BITS-1:0] max_repeats_ff, max_repeats_in;
   logic [LEN_BITS-1:0] limit;
   logic                csr_hit;

   // register index is the word address
   assign csr_hit = (paddr[CSR_ADDR_BITS-1] == CSR_IDX_MAX_REPEATS);
   assign pready  = 1'b1;

   always_comb begin
      max_repeats_in = max_repeats_ff;
      if (psel && penable && pwrite && csr_hit) begin
         max_repeats_in = pwdata[LEN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_repeats_ff <= MAX_REPEATS_RESET;
      end else begin
         max_repeats_ff <= max_repeats_in;
      end
   end

   assign prdata = csr_hit ? CSR_DATA_BITS'(max_repeats_ff) : '0;

   // a zero limit behaves as one
   assign limit = (max_repeats_ff == '0) ? LEN_BITS'(1) : max_repeats_ff;

   brwt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   brwt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_value         (req_value),
      .req_last_item     (req_last_item),
      .limit             (limit),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_window_length (rsp_window_length),
      .rsp_best_length   (rsp_best_length),
      .rsp_sequence_done (rsp_sequence_done)
   );

endmodule
